// ===== sv/lattice_path_count_blocked_edges_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Lattice path counter assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LATTICE_PATH_COUNT_BLOCKED_EDGES_UNIT_MACROS_SVH
`define LATTICE_PATH_COUNT_BLOCKED_EDGES_UNIT_MACROS_SVH

// same-cycle implication
`define LPCBE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define LPCBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/lpcbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Lattice path counter package
// Field widths, codes, controller states and the structs passed between
// the controller and the column cells.
// ----------------------------------------------------------------------------
package lpcbe_pkg;

    localparam int COORD_W   = 6;
    localparam int COUNT_W   = 63;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 6;

    // item operation codes
    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    // one wavefront token: row index and the count for that row
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] y;
        logic [COUNT_W-1:0] cnt;
    } t_link;

    // blocked-edge write, addressed by the upper endpoint
    typedef struct packed {
        logic               we;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               left;
        logic               below;
    } t_edge_wr;

endpackage

// ===== sv/lpcbe_cell.sv =====
// ----------------------------------------------------------------------------
// Lattice path counter column cell
// Holds the blocked flags of one column in small memories and its running
// count; reads the flags of a token's row in a first stage, computes the
// count in a second and hands the token on to the next column.
// ----------------------------------------------------------------------------
module lpcbe_cell #(
    parameter int MAX_DIM = 32,
    parameter int CELL_X  = 0,
    localparam int IDX_W  = $clog2(MAX_DIM + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lpcbe_pkg::t_link       i_link,
    input  lpcbe_pkg::t_edge_wr    i_wr,
    input  logic                   i_clear,
    input  logic [IDX_W-1:0]       i_clear_row,
    input  logic [IDX_W-1:0]       i_w,
    output lpcbe_pkg::t_link       o_link
);

    logic                           r_left  [0:MAX_DIM];
    logic                           r_below [0:MAX_DIM];
    logic                           r_left_rd;
    logic                           r_below_rd;
    lpcbe_pkg::t_link               r_pipe;
    lpcbe_pkg::t_link               r_link;

    logic [IDX_W-1:0]               rd_idx;
    logic [IDX_W-1:0]               wr_idx;
    logic                           wr_hit;
    logic                           active;
    logic [lpcbe_pkg::COUNT_W-1:0]  add_left;
    logic [lpcbe_pkg::COUNT_W-1:0]  add_below;
    logic [lpcbe_pkg::COUNT_W-1:0]  n_cnt;

    always_comb begin
        rd_idx    = i_link.y[IDX_W-1:0];
        wr_idx    = i_wr.y[IDX_W-1:0];
        wr_hit    = i_wr.we && (i_wr.x == lpcbe_pkg::COORD_W'(CELL_X));
        // columns past the destination drop the wavefront
        active    = (IDX_W'(CELL_X) <= i_w);
        add_left  = ((CELL_X != 0) && !r_left_rd) ? r_pipe.cnt : '0;
        add_below = ((r_pipe.y != '0) && !r_below_rd) ? r_link.cnt : '0;
        if ((CELL_X == 0) && (r_pipe.y == '0)) begin
            n_cnt = lpcbe_pkg::COUNT_W'(1);
        end else begin
            n_cnt = add_left + add_below;
        end
    end

    // flag memories: wiped one row per cycle, set by edge writes
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_left[i_clear_row]  <= 1'b0;
            r_below[i_clear_row] <= 1'b0;
        end else if (wr_hit) begin
            if (i_wr.left) begin
                r_left[wr_idx] <= 1'b1;
            end
            if (i_wr.below) begin
                r_below[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left_rd  <= r_left[rd_idx];
        r_below_rd <= r_below[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
            r_link.valid <= 1'b0;
        end else begin
            r_pipe.valid <= i_link.valid && active;
            r_link.valid <= r_pipe.valid;
            if (i_link.valid && active) begin
                r_pipe.y   <= i_link.y;
                r_pipe.cnt <= i_link.cnt;
            end
            if (r_pipe.valid) begin
                r_link.y   <= r_pipe.y;
                r_link.cnt <= n_cnt;
            end
        end
    end

    assign o_link = r_link;

endmodule

// ===== sv/lattice_path_count_blocked_edges_unit.sv =====
// ----------------------------------------------------------------------------
// Lattice path counter with blocked edges
// Counts monotone lattice paths from the origin to (width, height) that avoid
// blocked unit edges, using a wavefront through a row of column cells.
//
//   channel   signals                                    direction
//   item in   i_valid/o_ready, i_op, i_first_*, i_second_*   in
//   result    o_valid/i_ready, o_path_count                 out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data               in
//
// Edge items are taken one per cycle, back to back, while the controller is
// idle. A compute item's result is set by the wavefront crossing the column
// cells (w, h clipped to MAX_DIM), two stages each.
// Reset and each loaded result start a clearing pass over all MAX_DIM + 1
// rows of the blocked map, one row per cycle, with o_ready low.
// A waiting result does not block edge items; a second compute item holds
// its finished count until the output register frees up.
// ----------------------------------------------------------------------------
`include "lattice_path_count_blocked_edges_unit_macros.svh"

module lattice_path_count_blocked_edges_unit #(
    parameter int MAX_DIM = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_op,
    input  logic [lpcbe_pkg::COORD_W-1:0]         i_first_x,
    input  logic [lpcbe_pkg::COORD_W-1:0]         i_first_y,
    input  logic [lpcbe_pkg::COORD_W-1:0]         i_second_x,
    input  logic [lpcbe_pkg::COORD_W-1:0]         i_second_y,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [lpcbe_pkg::COUNT_W-1:0]         o_path_count,
    input  logic                                  i_cfg_we,
    input  logic [lpcbe_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lpcbe_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_DIM + 1);
    localparam int CW    = lpcbe_pkg::COORD_W;

    lpcbe_pkg::t_state              r_state;
    lpcbe_pkg::t_state              n_state;
    logic [CW-1:0]                  r_grid_width;
    logic [CW-1:0]                  r_grid_height;
    logic                           r_issuing;
    logic [IDX_W-1:0]               r_row;
    logic [IDX_W-1:0]               r_clr_row;
    logic                           r_out_valid;
    logic [lpcbe_pkg::COUNT_W-1:0]  r_path_count;

    logic                           in_fire;
    logic                           start;
    logic                           load;
    logic                           clear;
    logic                           done;
    logic                           out_free;
    logic [IDX_W-1:0]               w_clip;
    logic [IDX_W-1:0]               h_clip;
    logic                           in_range;
    logic                           horiz;
    logic                           vert;
    lpcbe_pkg::t_edge_wr            edge_wr;
    lpcbe_pkg::t_link               w_in  [0:MAX_DIM];
    lpcbe_pkg::t_link               w_out [0:MAX_DIM];

    assign in_fire  = i_valid && o_ready;
    assign start    = in_fire && (i_op == lpcbe_pkg::OP_COMPUTE);
    assign out_free = !r_out_valid || i_ready;
    assign w_clip   = (r_grid_width > CW'(MAX_DIM)) ? IDX_W'(MAX_DIM)
                                                    : r_grid_width[IDX_W-1:0];
    assign h_clip   = (r_grid_height > CW'(MAX_DIM)) ? IDX_W'(MAX_DIM)
                                                     : r_grid_height[IDX_W-1:0];
    assign done     = w_out[w_clip].valid && (w_out[w_clip].y == CW'(h_clip));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= '0;
            r_grid_height <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lpcbe_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                lpcbe_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // edge decode: either endpoint order, upper endpoint takes the flag
    always_comb begin
        in_range = (i_first_x  <= CW'(MAX_DIM)) && (i_first_y  <= CW'(MAX_DIM)) &&
                   (i_second_x <= CW'(MAX_DIM)) && (i_second_y <= CW'(MAX_DIM));
        horiz = (i_first_y == i_second_y) &&
                (({1'b0, i_first_x} + 7'd1 == {1'b0, i_second_x}) ||
                 ({1'b0, i_second_x} + 7'd1 == {1'b0, i_first_x}));
        vert  = (i_first_x == i_second_x) &&
                (({1'b0, i_first_y} + 7'd1 == {1'b0, i_second_y}) ||
                 ({1'b0, i_second_y} + 7'd1 == {1'b0, i_first_y}));
        edge_wr.we    = in_fire && (i_op == lpcbe_pkg::OP_EDGE) && in_range &&
                        (horiz || vert);
        edge_wr.x     = (i_first_x > i_second_x) ? i_first_x : i_second_x;
        edge_wr.y     = (i_first_y > i_second_y) ? i_first_y : i_second_y;
        edge_wr.left  = horiz;
        edge_wr.below = vert;
    end

    // controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpcbe_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        load    = 1'b0;
        clear   = 1'b0;
        case (r_state)
            lpcbe_pkg::ST_CLEAR: begin
                clear = 1'b1;
                if (r_clr_row == IDX_W'(MAX_DIM)) begin
                    n_state = lpcbe_pkg::ST_IDLE;
                end
            end
            lpcbe_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (start) begin
                    n_state = lpcbe_pkg::ST_SWEEP;
                end
            end
            lpcbe_pkg::ST_SWEEP: begin
                if (done) begin
                    n_state = lpcbe_pkg::ST_FINISH;
                end
            end
            lpcbe_pkg::ST_FINISH: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = lpcbe_pkg::ST_CLEAR;
                end
            end
            default: begin
                n_state = lpcbe_pkg::ST_CLEAR;
            end
        endcase
    end

    // clearing pass row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (clear) begin
            if (r_clr_row == IDX_W'(MAX_DIM)) begin
                r_clr_row <= '0;
            end else begin
                r_clr_row <= r_clr_row + IDX_W'(1);
            end
        end
    end

    // row tokens into column 0, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_row     <= '0;
        end else if (start) begin
            r_issuing <= 1'b1;
            r_row     <= '0;
        end else if (r_issuing) begin
            if (r_row == h_clip) begin
                r_issuing <= 1'b0;
            end else begin
                r_row <= r_row + IDX_W'(1);
            end
        end
    end

    assign w_in[0] = '{valid: r_issuing, y: CW'(r_row), cnt: '0};

    for (genvar gi = 0; gi <= MAX_DIM; gi++) begin : g_cell
        if (gi > 0) begin : g_link
            assign w_in[gi] = w_out[gi-1];
        end
        lpcbe_cell #(
            .MAX_DIM (MAX_DIM),
            .CELL_X  (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_link      (w_in[gi]),
            .i_wr        (edge_wr),
            .i_clear     (clear),
            .i_clear_row (r_clr_row),
            .i_w         (w_clip),
            .o_link      (w_out[gi])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_path_count <= w_out[w_clip].cnt;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_path_count = r_path_count;

    `LPCBE_ASSERT_IMP(a_issue_in_sweep, r_issuing, r_state == lpcbe_pkg::ST_SWEEP)
    `LPCBE_ASSERT_NEXT(a_start_issues_row0, start, r_issuing && (r_row == '0))
    `LPCBE_ASSERT_NEXT(a_finish_loads, load, o_valid && (r_state == lpcbe_pkg::ST_CLEAR))

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Lattice path counter testbench
// Drives blocked-edge and compute items through the valid/ready channels.
// Grid sizes are changed between phases while the block is idle. A scoreboard
// keeps its own blocked map and sweeps the grid to predict each path count.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COORD_W   = lpcbe_pkg::COORD_W;
    localparam int COUNT_W   = lpcbe_pkg::COUNT_W;
    localparam int CFG_IDX_W = lpcbe_pkg::CFG_IDX_W;
    localparam int CFG_W     = lpcbe_pkg::CFG_W;

    localparam int GRID_MAX      = 32;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1200;

    localparam bit [1:0] FROM_LEFT  = 2'b01;
    localparam bit [1:0] FROM_BELOW = 2'b10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_op;
    logic [COORD_W-1:0]   i_first_x;
    logic [COORD_W-1:0]   i_first_y;
    logic [COORD_W-1:0]   i_second_x;
    logic [COORD_W-1:0]   i_second_y;
    logic                 o_valid;
    logic                 i_ready;
    logic [COUNT_W-1:0]   o_path_count;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bit          steady;
    int unsigned cycle_count = 0;

    class path_count_board;
        bit [1:0]         blocked [0:GRID_MAX][0:GRID_MAX];
        bit [CFG_W-1:0]   width_reg;
        bit [CFG_W-1:0]   height_reg;
        bit [COUNT_W-1:0] pending_counts [$];
        int               fails;

        function new();
            clear_map();
            width_reg  = '0;
            height_reg = '0;
            fails      = 0;
        endfunction

        function void clear_map();
            for (int x = 0; x <= GRID_MAX; x++) begin
                for (int y = 0; y <= GRID_MAX; y++) begin
                    blocked[x][y] = '0;
                end
            end
        endfunction

        function int clip(bit [CFG_W-1:0] v);
            return (v > GRID_MAX) ? GRID_MAX : int'(v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == lpcbe_pkg::CFG_GRID_WIDTH) begin
                width_reg = val;
            end else begin
                height_reg = val;
            end
        endfunction

        function void note_item(logic op, logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                                logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
            int               ax, ay, bx, by, ux, uy, w, h;
            bit [1:0]         flag;
            bit [1:0]         b;
            bit [COUNT_W-1:0] row [0:GRID_MAX];
            bit [COUNT_W-1:0] sum;
            if (op == lpcbe_pkg::OP_EDGE) begin
                ax = int'(fx);
                ay = int'(fy);
                bx = int'(sx);
                by = int'(sy);
                if (ax > GRID_MAX || ay > GRID_MAX || bx > GRID_MAX || by > GRID_MAX) begin
                    return;
                end
                if (ay == by && (ax + 1 == bx || bx + 1 == ax)) begin
                    ux   = (ax > bx) ? ax : bx;
                    uy   = ay;
                    flag = FROM_LEFT;
                end else if (ax == bx && (ay + 1 == by || by + 1 == ay)) begin
                    ux   = ax;
                    uy   = (ay > by) ? ay : by;
                    flag = FROM_BELOW;
                end else begin
                    return;
                end
                blocked[ux][uy] |= flag;
            end else begin
                w = clip(width_reg);
                h = clip(height_reg);
                for (int y = 0; y <= h; y++) begin
                    for (int x = 0; x <= w; x++) begin
                        if (x == 0 && y == 0) begin
                            row[0] = COUNT_W'(1);
                        end else begin
                            b   = blocked[x][y];
                            sum = '0;
                            if (x > 0 && !b[0]) sum = sum + row[x-1];
                            if (y > 0 && !b[1]) sum = sum + row[x];
                            row[x] = sum;
                        end
                    end
                end
                pending_counts = {pending_counts, row[w]};
                clear_map();
            end
        endfunction

        function void check_count(logic [COUNT_W-1:0] actual);
            bit [COUNT_W-1:0] expected;
            if (pending_counts.size() == 0) begin
                $display("%0t: path count %0d arrived with none expected", $time, actual);
                fails++;
            end else begin
                expected = pending_counts.pop_front();
                if (actual !== expected) begin
                    $display("%0t: path count mismatch, expected %0d, actual %0d",
                             $time, expected, actual);
                    fails++;
                end
            end
        endfunction
    endclass

    path_count_board board;

    lattice_path_count_blocked_edges_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_path_count (o_path_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 0;
        if (r < 16) return GRID_MAX;
        if (r < 24) return $urandom_range(GRID_MAX + 1, 63);
        if (r < 60) return $urandom_range(1, 6);
        return $urandom_range(0, GRID_MAX);
    endfunction

    task automatic send_item(logic op, logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                             logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
        @(negedge i_clk);
        i_valid    = 1'b1;
        i_op       = op;
        i_first_x  = fx;
        i_first_y  = fy;
        i_second_x = sx;
        i_second_y = sy;
        do @(posedge i_clk); while (!o_ready);
        board.note_item(op, fx, fy, sx, sy);
    endtask

    // coordinate fields carry random content on compute items
    task automatic send_compute();
        send_item(lpcbe_pkg::OP_COMPUTE, COORD_W'($urandom_range(0, 63)),
                  COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)),
                  COORD_W'($urandom_range(0, 63)));
    endtask

    task automatic idle_gap();
        int g;
        g = steady ? 0 : gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_results(bit settle);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (board.pending_counts.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = CFG_W'(val);
        board.write_reg(idx, CFG_W'(val));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_dims(int w, int h);
        wait_results(1'b1);
        if ($urandom_range(0, 1)) begin
            write_reg(lpcbe_pkg::CFG_GRID_WIDTH, w);
            write_reg(lpcbe_pkg::CFG_GRID_HEIGHT, h);
        end else begin
            write_reg(lpcbe_pkg::CFG_GRID_HEIGHT, h);
            write_reg(lpcbe_pkg::CFG_GRID_WIDTH, w);
        end
    endtask

    initial begin
        int n, g;
        i_ready = 1'b0;
        forever begin
            n = $urandom_range(1, 20);
            repeat (n) begin
                @(negedge i_clk);
                i_ready = 1'b1;
            end
            g = steady ? 0 : gap_len();
            repeat (g) begin
                @(negedge i_clk);
                i_ready = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_count(o_path_count);
        end
    end

    initial begin
        int               w, h, r, dir, lw, lh, ux, uy, lx, ly, n_cases, n_edges;
        int               random_done;
        bit               counts;
        logic [COORD_W-1:0] a, b, c, d;
        board       = new();
        random_done = 0;
        steady      = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_op        = lpcbe_pkg::OP_EDGE;
        i_first_x   = '0;
        i_first_y   = '0;
        i_second_x  = '0;
        i_second_y  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = lpcbe_pkg::CFG_GRID_WIDTH;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset grid is the origin alone
        send_compute();

        set_dims(GRID_MAX, GRID_MAX);
        send_item(lpcbe_pkg::OP_EDGE, 1, 0, 0, 0);      // endpoints in reverse order
        send_item(lpcbe_pkg::OP_EDGE, 0, 0, 1, 0);      // same edge again
        send_item(lpcbe_pkg::OP_EDGE, 0, 0, 1, 1);      // diagonal, ignored
        send_item(lpcbe_pkg::OP_EDGE, 33, 0, 32, 0);    // beyond the largest grid
        send_item(lpcbe_pkg::OP_EDGE, 63, 63, 63, 62);
        send_item(lpcbe_pkg::OP_EDGE, 32, 31, 32, 32);
        send_item(lpcbe_pkg::OP_EDGE, 5, 5, 5, 5);      // same point
        send_compute();
        send_compute();                                 // map cleared, full count

        set_dims(63, 5);                                // width saturates
        send_item(lpcbe_pkg::OP_EDGE, 3, 7, 3, 6);      // outside this grid
        send_item(lpcbe_pkg::OP_EDGE, 2, 0, 2, 1);
        send_compute();

        set_dims(0, GRID_MAX);
        send_item(lpcbe_pkg::OP_EDGE, 0, 10, 0, 9);     // cuts the only column
        send_compute();
        send_compute();

        set_dims(7, 63);
        send_item(lpcbe_pkg::OP_EDGE, 7, 32, 6, 32);
        send_item(lpcbe_pkg::OP_EDGE, 7, 31, 7, 32);    // destination closed off
        send_compute();

        while (random_done < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            set_dims(pick_dim(), pick_dim());
            w       = board.clip(board.width_reg);
            h       = board.clip(board.height_reg);
            n_cases = $urandom_range(1, 6);
            repeat (n_cases) begin
                r = $urandom_range(0, 99);
                if (r < 70)      n_edges = $urandom_range(0, 6);
                else if (r < 95) n_edges = $urandom_range(7, 20);
                else             n_edges = $urandom_range(21, 40);
                repeat (n_edges) begin
                    r = $urandom_range(0, 99);
                    if (r < 10) begin
                        // noise, mostly ignored by the block
                        a      = COORD_W'($urandom_range(0, 63));
                        b      = COORD_W'($urandom_range(0, 63));
                        c      = COORD_W'($urandom_range(0, 63));
                        d      = COORD_W'($urandom_range(0, 63));
                        counts = 1'b0;
                    end else begin
                        lw = (r < 85) ? w : GRID_MAX;
                        lh = (r < 85) ? h : GRID_MAX;
                        if (lw == 0 && lh == 0) begin
                            lw = GRID_MAX;
                            lh = GRID_MAX;
                        end
                        dir = $urandom_range(0, 1);
                        if (lw == 0) dir = 1;
                        if (lh == 0) dir = 0;
                        if (dir == 0) begin
                            ux = $urandom_range(1, lw);
                            uy = $urandom_range(0, lh);
                            lx = ux - 1;
                            ly = uy;
                        end else begin
                            ux = $urandom_range(0, lw);
                            uy = $urandom_range(1, lh);
                            lx = ux;
                            ly = uy - 1;
                        end
                        if ($urandom_range(0, 1)) begin
                            a = COORD_W'(ux); b = COORD_W'(uy);
                            c = COORD_W'(lx); d = COORD_W'(ly);
                        end else begin
                            a = COORD_W'(lx); b = COORD_W'(ly);
                            c = COORD_W'(ux); d = COORD_W'(uy);
                        end
                        counts = 1'b1;
                    end
                    send_item(lpcbe_pkg::OP_EDGE, a, b, c, d);
                    random_done += int'(counts);
                    idle_gap();
                end
                send_compute();
                random_done++;
                idle_gap();
                if ($urandom_range(0, 9) == 0) wait_results(1'b0);
            end
        end

        wait_results(1'b1);
        if (board.fails == 0 && board.pending_counts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lpcbe_pkg.sv
sv/lpcbe_cell.sv
sv/lattice_path_count_blocked_edges_unit.sv
test/tb_top.sv
